FILE: hdl/skvt_pkg.sv
package skvt_pkg;
    localparam int CAPACITY_DEF  = 32;
    localparam int KEY_BYTES_DEF = 8;

    typedef enum logic [2:0] {
        MODE_SET     = 3'd0,
        MODE_LOOKUP  = 3'd1,
        MODE_REMOVE  = 3'd2,
        MODE_CLEAR   = 3'd3,
        MODE_FLOOR   = 3'd4,
        MODE_CEILING = 3'd5,
        MODE_FIRST   = 3'd6,
        MODE_LAST    = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    // one broadcast request seen by every cell
    typedef struct packed {
        logic        do_insert;
        logic        do_remove;
        logic        do_update;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
    } bcast_t;

    // what a cell hands to its neighbors
    typedef struct packed {
        logic        occ;
        logic        lt;
        logic        eq;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
    } cell_t;
endpackage

FILE: hdl/skvt_cell.sv
module skvt_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  skvt_pkg::bcast_t req,
    input  skvt_pkg::cell_t left,
    input  skvt_pkg::cell_t right,
    output skvt_pkg::cell_t self
);
    import skvt_pkg::*;

    logic        occ_reg, occ_next;
    logic [63:0] key_reg, key_next;
    logic [3:0]  len_reg, len_next;
    logic [63:0] value_reg, value_next;
    logic        lt, eq;

    // stored key below the request key
    assign lt = (key_reg < req.key) || (key_reg == req.key && len_reg < req.len);
    assign eq = (key_reg == req.key) && (len_reg == req.len);

    assign self.occ   = occ_reg;
    assign self.lt    = occ_reg && lt;
    assign self.eq    = occ_reg && eq;
    assign self.key   = key_reg;
    assign self.len   = len_reg;
    assign self.value = value_reg;

    always_comb
    begin
        occ_next   = occ_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        value_next = value_reg;
        if (req.do_insert)
        begin
            if (!self.lt)
            begin
                if (left.lt)
                begin
                    // first cell at or above the key takes the new entry
                    occ_next   = 1'b1;
                    key_next   = req.key;
                    len_next   = req.len;
                    value_next = req.value;
                end
                else
                begin
                    // left neighbor also above the key: take its entry
                    occ_next   = left.occ;
                    key_next   = left.key;
                    len_next   = left.len;
                    value_next = left.value;
                end
            end
        end
        else if (req.do_remove)
        begin
            if (!self.lt)
            begin
                occ_next   = right.occ;
                key_next   = right.key;
                len_next   = right.len;
                value_next = right.value;
            end
        end
        else if (req.do_update && self.eq)
        begin
            value_next = req.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else if (clear)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        len_reg   <= len_next;
        value_reg <= value_next;
    end
endmodule

FILE: hdl/sorted_key_value_table_top.sv
// channel | signals                                          | dir
// in      | valid, stall, mode, key_bytes, key_length, entry_value | into block
// out     | out_valid, out_stall, hit, out_key, out_key_length,    | out of block
//         | out_value, entry_count, table_full                      |
// the accepting edge registers the item; the next cycle compares the key in every
// cell of the chain, shifts the chain and registers the result
// stall stays high from acceptance until the result is taken, so the block takes
// no new item while one is still in flight
// reset clears the occupancy bits and the count
module sorted_key_value_table_top
#(
    parameter int CAPACITY  = skvt_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = skvt_pkg::KEY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [2:0]  mode,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_length,
    input  logic [63:0] entry_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [63:0] out_key,
    output logic [3:0]  out_key_length,
    output logic [63:0] out_value,
    output logic [5:0]  entry_count,
    output logic        table_full
);
    import skvt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_t      state_reg, state_next;
    mode_t       mode_reg;
    logic [63:0] key_reg, value_reg;
    logic [3:0]  len_reg;
    logic [CW-1:0] count_reg, count_next;
    bcast_t      req;
    cell_t       cells [CAPACITY];
    cell_t       lefts [CAPACITY];
    cell_t       rights [CAPACITY];
    logic        clear;
    logic        any_eq;
    logic [CW-1:0] n_lt;
    logic        ans;
    cell_t       pick;
    logic        hit_next, full_next;
    logic        o_hit_reg, o_full_reg;
    logic [63:0] o_key_reg, o_value_reg;
    logic [3:0]  o_len_reg;
    logic [CW-1:0] o_count_reg;
    logic        o_valid_reg;
    logic [3:0]  len_c;
    logic [63:0] mask;

    assign len_c = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
    assign mask  = (len_c == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {len_c, 3'b000});

    always_comb
    begin
        any_eq = 1'b0;
        n_lt   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq = any_eq | cells[i].eq;
            n_lt   = n_lt + CW'(cells[i].lt);
        end
    end

    always_comb
    begin
        req.key   = key_reg;
        req.len   = len_reg;
        req.value = value_reg;
        req.do_update = (state_reg == ST_EXEC) && mode_reg == MODE_SET && any_eq;
        req.do_insert = (state_reg == ST_EXEC) && mode_reg == MODE_SET && !any_eq
                        && count_reg < CW'(CAPACITY);
        req.do_remove = (state_reg == ST_EXEC) && mode_reg == MODE_REMOVE && any_eq;
    end
    assign clear = (state_reg == ST_EXEC) && mode_reg == MODE_CLEAR;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
                assign lefts[g] = '{occ: 1'b1, lt: 1'b1, default: '0};
            else
                assign lefts[g] = cells[g-1];
            if (g == CAPACITY - 1)
                assign rights[g] = '0;
            else
                assign rights[g] = cells[g+1];
            skvt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (clear),
                .req   (req),
                .left  (lefts[g]),
                .right (rights[g]),
                .self  (cells[g])
            );
        end
    endgenerate

    always_comb
    begin
        ans  = 1'b0;
        pick = '0;
        hit_next  = 1'b0;
        full_next = 1'b0;
        count_next = count_reg;
        case (mode_reg)
            MODE_SET:
            begin
                hit_next = any_eq;
                if (!any_eq && count_reg >= CW'(CAPACITY))
                    full_next = 1'b1;
                else if (!any_eq)
                    count_next = count_reg + 1'b1;
            end
            MODE_REMOVE:
            begin
                hit_next = any_eq;
                if (any_eq)
                    count_next = count_reg - 1'b1;
            end
            MODE_CLEAR:   count_next = '0;
            MODE_LOOKUP:
            begin
                ans = any_eq;
                for (int i = 0; i < CAPACITY; i++)
                    if (cells[i].eq) pick = cells[i];
            end
            MODE_FLOOR:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (cells[i].lt || cells[i].eq)
                    begin
                        ans  = 1'b1;
                        pick = cells[i];
                    end
            end
            MODE_CEILING:
            begin
                ans = n_lt < count_reg;
                for (int i = 0; i < CAPACITY; i++)
                    if (CW'(i) == n_lt) pick = cells[i];
            end
            MODE_FIRST:
            begin
                ans  = count_reg != '0;
                pick = cells[0];
            end
            default:
            begin
                ans = count_reg != '0;
                for (int i = 0; i < CAPACITY; i++)
                    if (CW'(i + 1) == count_reg) pick = cells[i];
            end
        endcase
        if (ans)
            hit_next = 1'b1;
        else
            pick = '0;
    end

    assign stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC)
            begin
                count_reg   <= count_next;
                o_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_OUT && !out_stall)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && valid)
        begin
            mode_reg  <= mode_t'(mode);
            key_reg   <= key_bytes & mask;
            len_reg   <= len_c;
            value_reg <= entry_value;
        end
        if (state_reg == ST_EXEC)
        begin
            o_hit_reg   <= hit_next;
            o_full_reg  <= full_next;
            o_key_reg   <= pick.key;
            o_len_reg   <= pick.len;
            o_value_reg <= pick.value;
            o_count_reg <= count_next;
        end
    end

    assign out_valid      = o_valid_reg;
    assign hit            = o_hit_reg;
    assign table_full     = o_full_reg;
    assign out_key        = o_key_reg;
    assign out_key_length = o_len_reg;
    assign out_value      = o_value_reg;
    assign entry_count    = 6'(o_count_reg);
endmodule

FILE: dv/sorted_key_value_table_top_test.sv
`timescale 1ns / 100ps

module sorted_key_value_table_top_test;
    import skvt_pkg::*;

    localparam int CAP = 32;
    localparam int KB = 8;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
    } request_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
        logic [5:0]  count;
        logic        full;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic [2:0]  mode;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [63:0] entry_value;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic [63:0] out_key;
    logic [3:0]  out_key_length;
    logic [63:0] out_value;
    logic [5:0]  entry_count;
    logic        table_full;

    sorted_key_value_table_top dut (.*);

    // shadow copy of the table
    logic [63:0] map_keys [CAP];
    logic [3:0]  map_lens [CAP];
    logic [63:0] map_vals [CAP];
    int          map_size;

    // keys already used, to revisit them
    logic [63:0] seen_keys [$];
    logic [3:0]  seen_lens [$];

    request_t pending_requests [$];
    answer_t  expected_answers [$];

    int  errors;
    int  sent;
    int  received;
    int  hits_seen;
    int  full_seen;
    bit  stim_done;
    bit  long_hold;
    int  gap_left;
    int  hold_left;

    function automatic int key_order(logic [63:0] ka, logic [3:0] la,
                                     logic [63:0] kb, logic [3:0] lb);
        if (ka != kb)
            return (ka < kb) ? -1 : 1;
        if (la != lb)
            return (la < lb) ? -1 : 1;
        return 0;
    endfunction

    // index of the first entry not below the key
    function automatic int find_slot(logic [63:0] k, logic [3:0] l, output bit exact);
        int lo;
        int hi;
        int mid;
        int c;
        lo = 0;
        hi = map_size;
        exact = 0;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            c = key_order(k, l, map_keys[mid], map_lens[mid]);
            if (c == 0)
            begin
                exact = 1;
                return mid;
            end
            if (c < 0)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        logic [3:0]  l;
        logic [63:0] k;
        bit exact;
        bit found;
        int idx;
        int pick;
        a = '0;
        found = 0;
        pick = 0;
        l = (r.len > KB) ? 4'(KB) : r.len;
        k = (l == 0) ? 64'd0 : (r.key & (~64'd0 << (64 - 8 * l)));
        case (r.mode)
            MODE_SET:
            begin
                idx = find_slot(k, l, exact);
                if (exact)
                begin
                    map_vals[idx] = r.value;
                    a.hit = 1;
                end
                else if (map_size >= CAP)
                    a.full = 1;
                else
                begin
                    for (int i = map_size; i > idx; i--)
                    begin
                        map_keys[i] = map_keys[i - 1];
                        map_lens[i] = map_lens[i - 1];
                        map_vals[i] = map_vals[i - 1];
                    end
                    map_keys[idx] = k;
                    map_lens[idx] = l;
                    map_vals[idx] = r.value;
                    map_size++;
                end
            end
            MODE_LOOKUP:
            begin
                idx = find_slot(k, l, exact);
                found = exact;
                pick = idx;
            end
            MODE_REMOVE:
            begin
                idx = find_slot(k, l, exact);
                if (exact)
                begin
                    for (int i = idx; i + 1 < map_size; i++)
                    begin
                        map_keys[i] = map_keys[i + 1];
                        map_lens[i] = map_lens[i + 1];
                        map_vals[i] = map_vals[i + 1];
                    end
                    map_size--;
                    a.hit = 1;
                end
            end
            MODE_CLEAR:
                map_size = 0;
            MODE_FLOOR:
            begin
                idx = find_slot(k, l, exact);
                if (exact)
                begin
                    found = 1;
                    pick = idx;
                end
                else if (idx > 0)
                begin
                    found = 1;
                    pick = idx - 1;
                end
            end
            MODE_CEILING:
            begin
                idx = find_slot(k, l, exact);
                found = idx < map_size;
                pick = idx;
            end
            MODE_FIRST:
            begin
                found = map_size > 0;
                pick = 0;
            end
            default:
            begin
                found = map_size > 0;
                pick = map_size - 1;
            end
        endcase
        if (found)
        begin
            a.hit = 1;
            a.key = map_keys[pick];
            a.len = map_lens[pick];
            a.value = map_vals[pick];
        end
        a.count = 6'(map_size);
        return a;
    endfunction

    function automatic request_t make_request(mode_t m, logic [63:0] k, logic [3:0] l,
                                              logic [63:0] v);
        request_t r;
        r.mode = m;
        r.key = k;
        r.len = l;
        r.value = v;
        return r;
    endfunction

    // small alphabet so keys collide and share prefixes
    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++)
            k[i * 8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, 2));
        return k;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int sel;
        int pick;
        r.value = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0 && seen_keys.size() > 0)
        begin
            pick = $urandom_range(0, seen_keys.size() - 1);
            r.key = seen_keys[pick];
            r.len = seen_lens[pick];
            // stray padding bits must not matter
            if ($urandom_range(0, 3) == 0)
                r.key = r.key | 64'({$urandom, $urandom} >> (8 * r.len));
        end
        else
        begin
            r.key = rand_key();
            r.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) :
                    4'($urandom_range(0, 8));
            seen_keys.push_back(r.key);
            seen_lens.push_back(r.len);
            if (seen_keys.size() > 60)
            begin
                void'(seen_keys.pop_front());
                void'(seen_lens.pop_front());
            end
        end
        sel = $urandom_range(0, 99);
        if (sel < 38)
            r.mode = MODE_SET;
        else if (sel < 52)
            r.mode = MODE_LOOKUP;
        else if (sel < 66)
            r.mode = MODE_REMOVE;
        else if (sel < 67)
            r.mode = MODE_CLEAR;
        else if (sel < 78)
            r.mode = MODE_FLOOR;
        else if (sel < 89)
            r.mode = MODE_CEILING;
        else if (sel < 94)
            r.mode = MODE_FIRST;
        else
            r.mode = MODE_LAST;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        #20ms;
        $display("timeout at %0t: %0d sent, %0d received", $time, sent, received);
        $display("TB_ERROR");
        $finish;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= 0;
            mode <= MODE_SET;
            key_bytes <= '0;
            key_length <= '0;
            entry_value <= '0;
            gap_left <= 0;
        end
        else if (!valid || !stall)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                valid <= 0;
            end
            else if (pending_requests.size() > 0)
            begin
                request_t r;
                r = pending_requests.pop_front();
                expected_answers.push_back(apply_request(r));
                valid <= 1;
                mode <= r.mode;
                key_bytes <= r.key;
                key_length <= r.len;
                entry_value <= r.value;
                sent <= sent + 1;
                if ($urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 6);
            end
            else
                valid <= 0;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            hold_left <= 0;
        end
        else if (long_hold && hold_left == 0)
        begin
            hold_left <= 300;
            out_stall <= 1;
        end
        else if (hold_left > 1)
            hold_left <= hold_left - 1;
        else if (hold_left == 1)
        begin
            hold_left <= 0;
            out_stall <= 0;
        end
        else if (received % 200 < 60)
            out_stall <= 0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            answer_t e;
            int bad;
            bad = 0;
            received <= received + 1;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result, hit %0b key %h", $time, hit, out_key);
                bad++;
            end
            else
            begin
                e = expected_answers.pop_front();
                if (hit) hits_seen <= hits_seen + 1;
                if (table_full) full_seen <= full_seen + 1;
                if (hit !== e.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                    bad++;
                end
                if (out_key !== e.key)
                begin
                    $display("%0t: out_key expected %h actual %h", $time, e.key, out_key);
                    bad++;
                end
                if (out_key_length !== e.len)
                begin
                    $display("%0t: out_key_length expected %0d actual %0d",
                             $time, e.len, out_key_length);
                    bad++;
                end
                if (out_value !== e.value)
                begin
                    $display("%0t: out_value expected %h actual %h", $time, e.value, out_value);
                    bad++;
                end
                if (entry_count !== e.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, e.count, entry_count);
                    bad++;
                end
                if (table_full !== e.full)
                begin
                    $display("%0t: table_full expected %0b actual %0b",
                             $time, e.full, table_full);
                    bad++;
                end
            end
            if (bad > 0)
                errors <= errors + bad;
        end
    end

    initial
    begin
        errors = 0;
        sent = 0;
        received = 0;
        hits_seen = 0;
        full_seen = 0;
        stim_done = 0;
        long_hold = 0;
        map_size = 0;

        // queries on an empty table
        pending_requests.push_back(make_request(MODE_FIRST, '1, 4'd8, '0));
        pending_requests.push_back(make_request(MODE_LAST, '0, 4'd0, '0));
        pending_requests.push_back(make_request(MODE_FLOOR, '1, 4'd8, '0));
        pending_requests.push_back(make_request(MODE_CEILING, '0, 4'd0, '0));
        pending_requests.push_back(make_request(MODE_LOOKUP, '0, 4'd0, '0));
        pending_requests.push_back(make_request(MODE_REMOVE, '0, 4'd0, '0));
        // empty key, all-ones key, prefix relations, overlong length, padding
        pending_requests.push_back(make_request(MODE_SET, 64'hffff, 4'd0, '1));
        pending_requests.push_back(make_request(MODE_SET, '1, 4'd8, 64'h1));
        pending_requests.push_back(make_request(MODE_SET, 64'h4100_0000_0000_0000, 4'd1, 64'h2));
        pending_requests.push_back(make_request(MODE_SET, 64'h4100_0000_0000_0000, 4'd2, 64'h3));
        pending_requests.push_back(make_request(MODE_SET, 64'h4142_ffff_ffff_ffff, 4'd15, 64'h4));
        pending_requests.push_back(make_request(MODE_SET, 64'h41ff_ffff_ffff_ffff, 4'd1, 64'h5));
        pending_requests.push_back(make_request(MODE_LOOKUP, 64'h4100_0000_0000_0000, 4'd2, '0));
        pending_requests.push_back(make_request(MODE_FLOOR, 64'h4141_0000_0000_0000, 4'd2, '0));
        pending_requests.push_back(make_request(MODE_CEILING, 64'h4141_0000_0000_0000, 4'd2, '0));
        pending_requests.push_back(make_request(MODE_FLOOR, '0, 4'd0, '0));
        pending_requests.push_back(make_request(MODE_CEILING, '1, 4'd9, '0));
        pending_requests.push_back(make_request(MODE_FIRST, '0, 4'd0, '0));
        pending_requests.push_back(make_request(MODE_LAST, '0, 4'd0, '0));
        pending_requests.push_back(make_request(MODE_REMOVE, 64'h4100_0000_0000_0000, 4'd1, '0));
        pending_requests.push_back(make_request(MODE_REMOVE, 64'h4100_0000_0000_0000, 4'd1, '0));
        pending_requests.push_back(make_request(MODE_CLEAR, '1, 4'd15, '1));
        pending_requests.push_back(make_request(MODE_LAST, '0, 4'd0, '0));

        // fill past capacity to exercise the full flag
        for (int i = 0; i < CAP + 3; i++)
            pending_requests.push_back(make_request(MODE_SET, {8'(i * 5), 56'd0}, 4'd1,
                                                    {$urandom, $urandom}));
        pending_requests.push_back(make_request(MODE_SET, 64'h0a00_0000_0000_0000, 4'd1, 64'h7));
        pending_requests.push_back(make_request(MODE_LAST, '0, 4'd0, '0));

        // hold the receiver off while the sender keeps offering
        wait (pending_requests.size() == 0 && sent > 20);
        long_hold = 1;
        wait (hold_left != 0);
        long_hold = 0;
        for (int i = 0; i < 10; i++)
            pending_requests.push_back(random_request());

        // pause until drained, then random traffic
        wait (pending_requests.size() == 0 && expected_answers.size() == 0);
        for (int i = 0; i < 1100; i++)
        begin
            pending_requests.push_back(random_request());
            if (i % 100 == 99)
                wait (pending_requests.size() < 20);
        end
        wait (pending_requests.size() == 0);
        stim_done = 1;
        wait (expected_answers.size() == 0 && !valid);
        repeat (20) @(posedge clk);

        $display("%0d requests checked, %0d hits, %0d refused inserts on a full table",
                 received, hits_seen, full_seen);
        if (errors == 0 && expected_answers.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sorted_key_value_table_top.f
hdl/skvt_pkg.sv
hdl/skvt_cell.sv
hdl/sorted_key_value_table_top.sv
dv/sorted_key_value_table_top_test.sv
